/* sv/ipfc_pkg.sv */
// ----------------------------------------------------------------------------
// ipfc_pkg
// Shared types, constants and helpers of the IP pair flow counter.
// ----------------------------------------------------------------------------
`default_nettype none

package ipfc_pkg;

   localparam int ENTRIES     = 16;   // flow table depth, 1..64
   localparam int COUNT_WIDTH = 32;   // stored packet count width, 8..32

   localparam int IP_W        = 32;
   localparam int MAC_W       = 48;
   localparam int RSP_COUNT_W = 32;

   localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W = $clog2(ENTRIES + 1);

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   localparam int REQ_DATA_W = 2 * IP_W + 2 * MAC_W;
   localparam int RSP_DATA_W = 2 * MAC_W + 2 * IP_W + RSP_COUNT_W;
   localparam int RSP_USER_W = 3;

   // command codes
   localparam logic CMD_OBSERVE = 1'b0;
   localparam logic CMD_DUMP    = 1'b1;

   typedef struct packed {
      logic [COUNT_WIDTH-1:0] count;
      logic [MAC_W-1:0]       dst_mac;
      logic [MAC_W-1:0]       src_mac;
      logic [IP_W-1:0]        dst_ip;
      logic [IP_W-1:0]        src_ip;
   } flow_entry_type;

   typedef struct packed {
      logic                   last;
      logic [RSP_COUNT_W-1:0] ref_count_out;
      logic [IP_W-1:0]        dst_ip_out;
      logic [IP_W-1:0]        src_ip_out;
      logic [MAC_W-1:0]       dst_mac_out;
      logic [MAC_W-1:0]       src_mac_out;
      logic                   table_full;
      logic                   hit;
      logic                   entry_valid;
   } rsp_word_type;

   function automatic rsp_word_type make_rsp(input flow_entry_type e, input logic hit,
                                             input logic last);
      rsp_word_type r;
      r.entry_valid   = 1'b1;
      r.hit           = hit;
      r.table_full    = 1'b0;
      r.src_mac_out   = e.src_mac;
      r.dst_mac_out   = e.dst_mac;
      r.src_ip_out    = e.src_ip;
      r.dst_ip_out    = e.dst_ip;
      r.ref_count_out = RSP_COUNT_W'(e.count);
      r.last          = last;
      return r;
   endfunction

endpackage

`default_nettype wire

/* sv/ipfc_ram.sv */
// ----------------------------------------------------------------------------
// ipfc_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ipfc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire                                     clock,
   input  wire                                     wr_en,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire [WIDTH-1:0]                         wr_data,
   input  wire                                     rd_en,
   input  wire [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                        rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* sv/ipfc_ctrl.sv */
// ----------------------------------------------------------------------------
// ipfc_ctrl
// Sequencer and shared key compare / count update unit over the flow RAM.
// ----------------------------------------------------------------------------
`default_nettype none

module ipfc_ctrl (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       in_valid,
   output logic                      in_ready,
   input  wire                       in_cmd,
   input  wire ipfc_pkg::flow_entry_type in_key,
   input  wire                       out_free,
   output logic                      push,
   output ipfc_pkg::rsp_word_type    rsp_word
);
   import ipfc_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_MISS  = 3'd2;
   localparam logic [2:0] S_DUMP  = 3'd3;
   localparam logic [2:0] S_EMPTY = 3'd4;

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

   logic [2:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] used_ff, used_in;
   flow_entry_type   key_ff, key_in;

   logic                          ram_we, ram_re;
   logic [IDX_W-1:0]              ram_wr_addr, ram_rd_addr;
   flow_entry_type                ram_wr_entry, rd_entry;
   logic [$bits(flow_entry_type)-1:0] ram_rd_data;

   logic           key_match, last_idx;
   flow_entry_type bumped;

   ipfc_ram #(
      .WIDTH($bits(flow_entry_type)),
      .DEPTH(ENTRIES)
   ) u_flow_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_entry),
      .rd_en  (ram_re),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   assign rd_entry  = flow_entry_type'(ram_rd_data);
   assign key_match = (rd_entry.src_ip == key_ff.src_ip) && (rd_entry.dst_ip == key_ff.dst_ip);
   assign last_idx  = (CNT_W'(idx_ff) == used_ff - CNT_W'(1));
   assign in_ready  = (state_ff == S_IDLE);

   always_comb begin
      bumped = rd_entry;
      if (rd_entry.count != COUNT_MAX) begin
         bumped.count = rd_entry.count + COUNT_WIDTH'(1);
      end
   end

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      used_in      = used_ff;
      key_in       = key_ff;
      ram_re       = 1'b0;
      ram_rd_addr  = idx_ff;
      ram_we       = 1'b0;
      ram_wr_addr  = idx_ff;
      ram_wr_entry = bumped;
      push         = 1'b0;
      rsp_word     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (in_valid) begin
               key_in       = in_key;
               key_in.count = COUNT_WIDTH'(1);
               if (in_cmd == CMD_DUMP) begin
                  if (used_ff == '0) begin
                     state_in = S_EMPTY;
                  end else begin
                     idx_in      = IDX_W'(used_ff - CNT_W'(1));
                     ram_re      = 1'b1;
                     ram_rd_addr = IDX_W'(used_ff - CNT_W'(1));
                     state_in    = S_DUMP;
                  end
               end else begin
                  if (used_ff == '0) begin
                     state_in = S_MISS;
                  end else begin
                     idx_in      = '0;
                     ram_re      = 1'b1;
                     ram_rd_addr = '0;
                     state_in    = S_SCAN;
                  end
               end
            end
         end
         S_SCAN: begin
            if (key_match) begin
               // write back the bumped count with the result word
               if (out_free) begin
                  ram_we   = 1'b1;
                  push     = 1'b1;
                  rsp_word = make_rsp(bumped, 1'b1, 1'b1);
                  state_in = S_IDLE;
               end
            end else if (last_idx) begin
               state_in = S_MISS;
            end else begin
               idx_in      = idx_ff + IDX_W'(1);
               ram_re      = 1'b1;
               ram_rd_addr = idx_ff + IDX_W'(1);
            end
         end
         S_MISS: begin
            if (out_free) begin
               push     = 1'b1;
               state_in = S_IDLE;
               if (used_ff == FULL_CNT) begin
                  rsp_word.table_full = 1'b1;
                  rsp_word.last       = 1'b1;
               end else begin
                  ram_we       = 1'b1;
                  ram_wr_addr  = IDX_W'(used_ff);
                  ram_wr_entry = key_ff;
                  used_in      = used_ff + CNT_W'(1);
                  rsp_word     = make_rsp(key_ff, 1'b0, 1'b1);
               end
            end
         end
         S_DUMP: begin
            // newest first, walking down to entry zero
            if (out_free) begin
               push     = 1'b1;
               rsp_word = make_rsp(rd_entry, 1'b0, idx_ff == '0);
               if (idx_ff == '0) begin
                  state_in = S_IDLE;
               end else begin
                  idx_in      = idx_ff - IDX_W'(1);
                  ram_re      = 1'b1;
                  ram_rd_addr = idx_ff - IDX_W'(1);
               end
            end
         end
         S_EMPTY: begin
            if (out_free) begin
               push          = 1'b1;
               rsp_word.last = 1'b1;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         used_ff  <= '0;
      end else begin
         state_ff <= state_in;
         used_ff  <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      key_ff <= key_in;
   end

   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= FULL_CNT)
      else $error("flow count above table depth");

   a_write_with_word: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> push)
      else $error("table write without a result word");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> out_free)
      else $error("result word pushed into a full output stage");

   a_last_ends_item: assert property (@(posedge clock) disable iff (reset)
      (push && rsp_word.last) |=> (state_ff == S_IDLE))
      else $error("sequencer busy after final word");

endmodule

`default_nettype wire

/* sv/ip_pair_flow_counter_core.sv */
// ----------------------------------------------------------------------------
// ip_pair_flow_counter_core
// Exact-match flow table keyed by source/destination IPv4 pair.
// ----------------------------------------------------------------------------
// Observe words look up the address pair by scanning the stored flows one
// entry per cycle through a single RAM read port and one key comparator: a
// hit bumps the saturating count, a miss appends the flow with count 1, or
// flags table_full when all ENTRIES slots are taken. An observe word's time
// grows with the hit position or the fill, bounded by the sequential scan
// of the table. A dump word returns every stored flow newest first, one
// word per cycle while the output stage has room, with tlast on the oldest;
// an empty table gives a single word with entry_valid low. The table has no
// valid bits and needs no clearing after reset. A registered output stage
// lets the next request in while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_pair_flow_counter_core (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // src_ip, dst_ip, src_mac, dst_mac
   input  wire [ipfc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // command
   input  wire                                req_tuser,
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // src_mac_out, dst_mac_out, src_ip_out, dst_ip_out, ref_count_out
   output logic [ipfc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // entry_valid, hit, table_full
   output logic [ipfc_pkg::RSP_USER_W-1:0]    rsp_tuser,
   output logic                               rsp_tlast
);
   import ipfc_pkg::*;

   flow_entry_type in_key;
   rsp_word_type   rsp_word, rsp_word_ff;
   logic           push, out_free;
   logic           rsp_valid_ff, rsp_valid_in;

   always_comb begin
      in_key         = '0;
      in_key.src_ip  = req_tdata[IP_W-1:0];
      in_key.dst_ip  = req_tdata[2*IP_W-1:IP_W];
      in_key.src_mac = req_tdata[2*IP_W+MAC_W-1:2*IP_W];
      in_key.dst_mac = req_tdata[2*IP_W+2*MAC_W-1:2*IP_W+MAC_W];
   end

   ipfc_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .in_valid(req_tvalid),
      .in_ready(req_tready),
      .in_cmd  (req_tuser),
      .in_key  (in_key),
      .out_free(out_free),
      .push    (push),
      .rsp_word(rsp_word)
   );

   // output word register
   assign out_free     = !rsp_valid_ff || rsp_tready;
   assign rsp_valid_in = push || (rsp_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         rsp_word_ff <= rsp_word;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_word_ff.last;
   assign rsp_tuser  = {rsp_word_ff.table_full, rsp_word_ff.hit, rsp_word_ff.entry_valid};
   assign rsp_tdata  = {rsp_word_ff.ref_count_out, rsp_word_ff.dst_ip_out,
                        rsp_word_ff.src_ip_out, rsp_word_ff.dst_mac_out,
                        rsp_word_ff.src_mac_out};

endmodule

`default_nettype wire

/* tb/ip_pair_flow_counter_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ip_pair_flow_counter_core_tb
// Self-checking bench for the IP pair flow table.
// ----------------------------------------------------------------------------
// Drives observe and dump words into the request stream and checks every
// response word against a local model of the flow table. A directed opening
// covers the empty dump, extreme keys and MACs, swapped address pairs, the
// full table and its dump. Random traffic then mixes hits on stored flows,
// new flows dropped on the full table, and dumps. Both streams idle at random,
// and the response side holds off once long enough to back up the request side.
// ----------------------------------------------------------------------------

module ip_pair_flow_counter_core_tb;

   import ipfc_pkg::*;

   localparam int NUM_WORDS   = 435;
   localparam int HOLD_CYCLES = 300;
   localparam int STALL_LIMIT = 2000;
   localparam int DRAIN_WAIT  = 60;

   // flow table model and store of expected response words
   class flow_table_model_type;
      flow_entry_type flows[ENTRIES];
      int unsigned    used;
      rsp_word_type   pending_words[$];
      int unsigned    errors;
      int unsigned    word_num;

      function new();
         used     = 0;
         errors   = 0;
         word_num = 0;
      endfunction

      function rsp_word_type entry_word(int idx);
         rsp_word_type r;
         r               = '0;
         r.entry_valid   = 1'b1;
         r.src_mac_out   = flows[idx].src_mac;
         r.dst_mac_out   = flows[idx].dst_mac;
         r.src_ip_out    = flows[idx].src_ip;
         r.dst_ip_out    = flows[idx].dst_ip;
         r.ref_count_out = RSP_COUNT_W'(flows[idx].count);
         return r;
      endfunction

      function void note_word(logic cmd, logic [IP_W-1:0] sip, logic [IP_W-1:0] dip,
                              logic [MAC_W-1:0] smac, logic [MAC_W-1:0] dmac);
         rsp_word_type r;
         int           idx;
         idx = -1;
         if (cmd == CMD_DUMP) begin
            if (used == 0) begin
               r      = '0;
               r.last = 1'b1;
               pending_words.push_back(r);
            end else begin
               for (int i = int'(used) - 1; i >= 0; i--) begin
                  r      = entry_word(i);
                  r.last = (i == 0);
                  pending_words.push_back(r);
               end
            end
            return;
         end
         for (int i = 0; i < int'(used); i++)
            if (idx < 0 && flows[i].src_ip == sip && flows[i].dst_ip == dip)
               idx = i;
         if (idx >= 0) begin
            if (flows[idx].count != COUNT_MAX)
               flows[idx].count = flows[idx].count + 1'b1;
            r     = entry_word(idx);
            r.hit = 1'b1;
         end else if (used >= ENTRIES) begin
            // no room: flow dropped
            r            = '0;
            r.table_full = 1'b1;
         end else begin
            flows[used].src_ip  = sip;
            flows[used].dst_ip  = dip;
            flows[used].src_mac = smac;
            flows[used].dst_mac = dmac;
            flows[used].count   = 1;
            r    = entry_word(used);
            used = used + 1;
         end
         r.last = 1'b1;
         pending_words.push_back(r);
      endfunction

      task report(string what, logic [63:0] got, logic [63:0] want);
         $display("ERROR word %0d: %s got %h expected %h", word_num, what, got, want);
         errors++;
      endtask

      task compare(string what, logic [63:0] got, logic [63:0] want);
         if (got !== want)
            report(what, got, want);
      endtask

      task check_word(logic [RSP_DATA_W-1:0] data, logic [RSP_USER_W-1:0] user,
                      logic last);
         rsp_word_type want;
         word_num++;
         if (pending_words.size() == 0) begin
            report("unexpected word, data", 64'(data), 64'd0);
            return;
         end
         want = pending_words.pop_front();
         compare("entry_valid", 64'(user[0]), 64'(want.entry_valid));
         compare("hit", 64'(user[1]), 64'(want.hit));
         compare("table_full", 64'(user[2]), 64'(want.table_full));
         compare("src_mac_out", 64'(data[47:0]), 64'(want.src_mac_out));
         compare("dst_mac_out", 64'(data[95:48]), 64'(want.dst_mac_out));
         compare("src_ip_out", 64'(data[127:96]), 64'(want.src_ip_out));
         compare("dst_ip_out", 64'(data[159:128]), 64'(want.dst_ip_out));
         compare("ref_count_out", 64'(data[191:160]), 64'(want.ref_count_out));
         compare("last", 64'(last), 64'(want.last));
      endtask
   endclass

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata;   // src_ip, dst_ip, src_mac, dst_mac
   logic                    req_tuser;   // command
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_DATA_W-1:0]   rsp_tdata;   // src_mac_out, dst_mac_out, src_ip_out,
                                         // dst_ip_out, ref_count_out
   logic [RSP_USER_W-1:0]   rsp_tuser;   // entry_valid, hit, table_full
   logic                    rsp_tlast;

   flow_table_model_type flow_model = new();

   logic        quiet     = 1'b0;
   logic        hold_req  = 1'b0;
   int unsigned hold_left = 0;
   int unsigned stall_cnt = 0;

   ip_pair_flow_counter_core i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   // response side: random back pressure plus one long hold-off
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left  = hold_left - 1;
         rsp_tready = 1'b0;
      end else if (hold_req) begin
         hold_req   = 1'b0;
         hold_left  = HOLD_CYCLES;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = quiet || ($urandom_range(0, 99) >= 35);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         flow_model.check_word(rsp_tdata, rsp_tuser, rsp_tlast);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         stall_cnt = 0;
      else
         stall_cnt = stall_cnt + 1;
      if (stall_cnt >= STALL_LIMIT) begin
         $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
         $display("** ip_pair_flow_counter_core: FAILED **");
         $finish;
      end
   end

   task send_word(logic cmd, logic [IP_W-1:0] sip, logic [IP_W-1:0] dip,
                  logic [MAC_W-1:0] smac, logic [MAC_W-1:0] dmac);
      while (!quiet && $urandom_range(0, 99) < 35) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {dmac, smac, dip, sip};
      do
         @(posedge clock);
      while (!req_tready);
      flow_model.note_word(cmd, sip, dip, smac, dmac);
      @(negedge clock);
   endtask

   function automatic logic [MAC_W-1:0] rand_mac();
      return MAC_W'({$urandom, $urandom});
   endfunction

   initial begin
      int unsigned      pick;
      int unsigned      k;
      logic [IP_W-1:0]  sip;
      logic [IP_W-1:0]  dip;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = CMD_OBSERVE;
      rsp_tready = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed opening
      send_word(CMD_DUMP, '1, '1, '1, '1);              // empty table
      send_word(CMD_OBSERVE, '0, '0, '0, '0);
      send_word(CMD_OBSERVE, '1, '1, '1, '1);
      send_word(CMD_OBSERVE, '0, '0, '1, '1);           // hit keeps first MACs
      send_word(CMD_OBSERVE, 32'h0A00_0001, 32'hC0A8_0001, rand_mac(), rand_mac());
      send_word(CMD_OBSERVE, 32'hC0A8_0001, 32'h0A00_0001, rand_mac(), rand_mac());
      send_word(CMD_OBSERVE, 32'h0A00_0001, 32'hC0A8_0002, rand_mac(), rand_mac());
      send_word(CMD_DUMP, '0, '0, '0, '0);
      while (flow_model.used < ENTRIES)
         send_word(CMD_OBSERVE, 32'h0100_0000 + flow_model.used, 32'h8000_00F0,
                   rand_mac(), rand_mac());
      send_word(CMD_OBSERVE, 32'h5555_5555, 32'hAAAA_AAAA, '1, '1);  // full, dropped
      send_word(CMD_OBSERVE, flow_model.flows[ENTRIES-1].src_ip,
                flow_model.flows[ENTRIES-1].dst_ip, '0, '0);
      send_word(CMD_OBSERVE, '0, '0, rand_mac(), rand_mac());
      send_word(CMD_DUMP, $urandom, $urandom, rand_mac(), rand_mac());

      // random traffic
      for (int n = 0; n < NUM_WORDS; n++) begin
         quiet = (n >= 300 && n < 380);
         if (n == 150)
            hold_req = 1'b1;
         pick = $urandom_range(0, 99);
         k    = $urandom_range(0, flow_model.used - 1);
         if (pick < 12) begin
            send_word(CMD_DUMP, $urandom, $urandom, rand_mac(), rand_mac());
         end else if (pick < 62) begin
            send_word(CMD_OBSERVE, flow_model.flows[k].src_ip, flow_model.flows[k].dst_ip,
                      rand_mac(), rand_mac());
         end else begin
            sip = $urandom;
            dip = $urandom;
            // near misses on a stored key
            case ($urandom_range(0, 3))
               0: begin
                  sip = flow_model.flows[k].dst_ip;
                  dip = flow_model.flows[k].src_ip;
               end
               1: sip = flow_model.flows[k].src_ip;
               default: ;
            endcase
            send_word(CMD_OBSERVE, sip, dip, rand_mac(), rand_mac());
         end
      end
      req_tvalid = 1'b0;
      quiet      = 1'b0;

      while (flow_model.pending_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (flow_model.pending_words.size() != 0)
         flow_model.report("words never seen", 64'd0, 64'(flow_model.pending_words.size()));
      if (flow_model.errors == 0)
         $display("** ip_pair_flow_counter_core: PASSED **");
      else
         $display("** ip_pair_flow_counter_core: FAILED **");
      $finish;
   end

endmodule
